// ===== hdl/pafk_pkg.sv =====
// shared types, constants and helper functions for the planar arm forward kinematics unit
// no dependencies; imported by every module of the block
`default_nettype none

package pafk_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int POS_WIDTH    = 24;
    localparam int OUT_W        = 24;
    localparam int EXT_W        = (POS_WIDTH > OUT_W) ? POS_WIDTH : OUT_W;
    localparam int CNT_W        = $clog2(CORDIC_STEPS);
    localparam int ANG_W        = 15;
    localparam int TURN_W       = 18;
    localparam int REM_W        = 13;
    localparam int LEN_W        = 16;
    localparam int TRIG_W       = 32;
    localparam int Z_W          = 27;
    localparam int PROD_W       = 49;
    localparam int DELTA_W      = 19;
    localparam int SUM_W        = ((POS_WIDTH > DELTA_W) ? POS_WIDTH : DELTA_W) + 1;
    localparam int DIFF_W       = OUT_W + 1;
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int DSQ_W        = SQ_W + 1;
    localparam int THR_W        = 23;
    localparam int TSQ_W        = 2 * THR_W;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam logic signed [TURN_W-1:0] FULL_TURN    = 18'sd23040;
    localparam logic signed [TURN_W-1:0] TWO_TURNS    = 18'sd46080;
    localparam logic [ANG_W-1:0]         QUARTER_TURN = 15'd5760;
    localparam logic [ANG_W-1:0]         HALF_TURN    = 15'd11520;
    localparam logic [ANG_W-1:0]         THREE_QUARTER = 15'd17280;
    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN  = 32'sd652032874;

    localparam logic [1:0] REG_TARGET_X       = 2'd0;
    localparam logic [1:0] REG_TARGET_Y       = 2'd1;
    localparam logic [1:0] REG_NEAR_THRESHOLD = 2'd2;

    typedef struct packed {
        logic [1:0]       quad;
        logic [REM_W-1:0] rem;
        logic [LEN_W-1:0] length;
        logic             start;
        logic             last;
    } seg_t;

    typedef struct packed {
        logic [OUT_W-1:0] target_x;
        logic [OUT_W-1:0] target_y;
        logic [THR_W-1:0] near_threshold;
    } cfg_t;

    function automatic logic signed [Z_W-1:0] atan_entry(input logic [4:0] idx);
        logic signed [Z_W-1:0] r;
        case (idx)
            5'd0:    r = 27'sd11796480;
            5'd1:    r = 27'sd6963869;
            5'd2:    r = 27'sd3679517;
            5'd3:    r = 27'sd1867780;
            5'd4:    r = 27'sd937515;
            5'd5:    r = 27'sd469214;
            5'd6:    r = 27'sd234664;
            5'd7:    r = 27'sd117339;
            5'd8:    r = 27'sd58671;
            5'd9:    r = 27'sd29335;
            5'd10:   r = 27'sd14668;
            5'd11:   r = 27'sd7334;
            5'd12:   r = 27'sd3667;
            5'd13:   r = 27'sd1833;
            5'd14:   r = 27'sd917;
            5'd15:   r = 27'sd458;
            5'd16:   r = 27'sd229;
            5'd17:   r = 27'sd115;
            5'd18:   r = 27'sd57;
            5'd19:   r = 27'sd29;
            5'd20:   r = 27'sd14;
            5'd21:   r = 27'sd7;
            5'd22:   r = 27'sd4;
            5'd23:   r = 27'sd2;
            default: r = '0;
        endcase
        return r;
    endfunction

    // clamp a widened sum back to the accumulator range
    function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-POS_WIDTH:0] hi;
        logic signed [POS_WIDTH-1:0] r;
        hi = v[SUM_W-1:POS_WIDTH-1];
        if ((&hi) || (~|hi))
            r = v[POS_WIDTH-1:0];
        else if (v[SUM_W-1])
            r = {1'b1, {(POS_WIDTH-1){1'b0}}};
        else
            r = {1'b0, {(POS_WIDTH-1){1'b1}}};
        return r;
    endfunction

    // clamp an accumulator to the output coordinate range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [POS_WIDTH-1:0] v);
        logic signed [EXT_W-1:0] e;
        logic [EXT_W-OUT_W:0] hi;
        logic signed [OUT_W-1:0] r;
        e  = EXT_W'(v);
        hi = e[EXT_W-1:OUT_W-1];
        if ((&hi) || (~|hi))
            r = e[OUT_W-1:0];
        else if (e[EXT_W-1])
            r = {1'b1, {(OUT_W-1){1'b0}}};
        else
            r = {1'b0, {(OUT_W-1){1'b1}}};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pafk_front.sv =====
// front end: accepts segment words, keeps the running angle and splits it into quadrant
// and remainder; depends on pafk_pkg
`default_nettype none

module pafk_front
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [15:0]               in_angle,
    input  wire logic [15:0]               in_length,
    input  wire logic                      in_start,
    input  wire logic                      in_last,
    input  wire logic                      q_full,
    output logic                           q_push,
    output pafk_pkg::seg_t                 q_data
);
    import pafk_pkg::*;

    logic [ANG_W-1:0]         angle_reg;
    logic [ANG_W-1:0]         angle_next;
    logic [ANG_W-1:0]         base;
    logic signed [TURN_W-1:0] total;
    logic signed [TURN_W-1:0] wrapped;
    logic [ANG_W-1:0]         wang;
    logic [ANG_W-1:0]         rem_full;
    logic [1:0]               quad;

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        base  = in_start ? '0 : angle_reg;
        total = $signed({{(TURN_W-ANG_W){1'b0}}, base}) + TURN_W'($signed(in_angle));
        if (total < -FULL_TURN)
            wrapped = total + TWO_TURNS;
        else if (total < 0)
            wrapped = total + FULL_TURN;
        else if (total < FULL_TURN)
            wrapped = total;
        else if (total < TWO_TURNS)
            wrapped = total - FULL_TURN;
        else
            wrapped = total - TWO_TURNS;
        wang = wrapped[ANG_W-1:0];
        if (wang >= THREE_QUARTER)
        begin
            quad     = 2'd3;
            rem_full = wang - THREE_QUARTER;
        end
        else if (wang >= HALF_TURN)
        begin
            quad     = 2'd2;
            rem_full = wang - HALF_TURN;
        end
        else if (wang >= QUARTER_TURN)
        begin
            quad     = 2'd1;
            rem_full = wang - QUARTER_TURN;
        end
        else
        begin
            quad     = 2'd0;
            rem_full = wang;
        end
        q_data.quad   = quad;
        q_data.rem    = rem_full[REM_W-1:0];
        q_data.length = in_length;
        q_data.start  = in_start;
        q_data.last   = in_last;
        angle_next    = q_push ? wang : angle_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            angle_reg <= '0;
        else
            angle_reg <= angle_next;
    end

endmodule

`default_nettype wire

// ===== hdl/pafk_queue.sv =====
// short queue of classified segments between front and back end
// depends on pafk_pkg
`default_nettype none

module pafk_queue
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire pafk_pkg::seg_t push_data,
    output logic                full,
    output logic                valid,
    output pafk_pkg::seg_t      pop_data,
    input  wire logic           pop
);
    import pafk_pkg::*;

    seg_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_pop;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem[rd_ptr_reg];
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCNT_W'(push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pafk_back.sv =====
// back end: iterative cordic, length scaling, position accumulation, target test and
// output register; depends on pafk_pkg
`default_nettype none

module pafk_back
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           q_valid,
    input  wire pafk_pkg::seg_t q_data,
    output logic                q_pop,
    input  wire pafk_pkg::cfg_t cfg,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [23:0]         out_x,
    output logic [23:0]         out_y,
    output logic                out_last,
    output logic                out_near
);
    import pafk_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_ROT  = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_ACC  = 6'b001000,
        ST_SQR  = 6'b010000,
        ST_DONE = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    seg_t                       seg_reg, seg_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic signed [TRIG_W-1:0]   x_reg, x_next;
    logic signed [TRIG_W-1:0]   y_reg, y_next;
    logic signed [Z_W-1:0]      z_reg, z_next;
    logic signed [PROD_W-1:0]   px_reg, px_next;
    logic signed [PROD_W-1:0]   py_reg, py_next;
    logic signed [POS_WIDTH-1:0] pos_x_reg, pos_x_next;
    logic signed [POS_WIDTH-1:0] pos_y_reg, pos_y_next;
    logic [DSQ_W-1:0]           dsq_reg, dsq_next;
    logic [TSQ_W-1:0]           tsq_reg, tsq_next;
    logic signed [OUT_W-1:0]    ox_reg, ox_next;
    logic signed [OUT_W-1:0]    oy_reg, oy_next;
    logic                       out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]           out_x_reg, out_x_next;
    logic [OUT_W-1:0]           out_y_reg, out_y_next;
    logic                       out_last_reg, out_last_next;
    logic                       out_near_reg, out_near_next;

    logic signed [TRIG_W-1:0]   sh_x, sh_y;
    logic signed [Z_W-1:0]      atan_val;
    logic signed [TRIG_W-1:0]   sin_val, cos_val;
    logic signed [LEN_W:0]      len_s;
    logic signed [PROD_W-1:0]   rnd_x, rnd_y;
    logic signed [DELTA_W-1:0]  delta_x, delta_y;
    logic signed [POS_WIDTH-1:0] base_x, base_y;
    logic signed [DIFF_W-1:0]   dx, dy;
    logic signed [SQ_W-1:0]     dx_sq, dy_sq;
    logic                       out_free;

    localparam logic signed [PROD_W-1:0] ROUND_HALF =
        {{(PROD_W-30){1'b0}}, 1'b1, {29{1'b0}}};

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_last  = out_last_reg;
    assign out_near  = out_near_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        seg_next       = seg_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        z_next         = z_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        ox_next        = ox_reg;
        oy_next        = oy_reg;
        dsq_next       = dsq_reg;
        tsq_next       = tsq_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_x_next     = out_x_reg;
        out_y_next     = out_y_reg;
        out_last_next  = out_last_reg;
        out_near_next  = out_near_reg;
        q_pop          = 1'b0;

        sh_x     = x_reg >>> cnt_reg;
        sh_y     = y_reg >>> cnt_reg;
        atan_val = atan_entry(5'(cnt_reg));

        case (seg_reg.quad)
            2'd0:
            begin
                sin_val = y_reg;
                cos_val = x_reg;
            end
            2'd1:
            begin
                sin_val = x_reg;
                cos_val = -y_reg;
            end
            2'd2:
            begin
                sin_val = -y_reg;
                cos_val = -x_reg;
            end
            default:
            begin
                sin_val = -x_reg;
                cos_val = y_reg;
            end
        endcase
        len_s = $signed({1'b0, seg_reg.length});

        rnd_x   = px_reg + ROUND_HALF;
        rnd_y   = py_reg + ROUND_HALF;
        delta_x = rnd_x[PROD_W-1:30];
        delta_y = rnd_y[PROD_W-1:30];
        base_x  = seg_reg.start ? '0 : pos_x_reg;
        base_y  = seg_reg.start ? '0 : pos_y_reg;

        dx    = DIFF_W'(ox_reg) - DIFF_W'($signed(cfg.target_x));
        dy    = DIFF_W'(oy_reg) - DIFF_W'($signed(cfg.target_y));
        dx_sq = dx * dx;
        dy_sq = dy * dy;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    seg_next   = q_data;
                    cnt_next   = '0;
                    x_next     = CORDIC_GAIN;
                    y_next     = '0;
                    z_next     = $signed({{(Z_W-REM_W-12){1'b0}}, q_data.rem, 12'd0});
                    state_next = ST_ROT;
                end
            end
            ST_ROT:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_next = x_reg - sh_y;
                    y_next = y_reg + sh_x;
                    z_next = z_reg - atan_val;
                end
                else
                begin
                    x_next = x_reg + sh_y;
                    y_next = y_reg - sh_x;
                    z_next = z_reg + atan_val;
                end
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
                    state_next = ST_MUL;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            ST_MUL:
            begin
                px_next    = len_s * sin_val;
                py_next    = len_s * cos_val;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                pos_x_next = sat_pos(SUM_W'(base_x) + SUM_W'(delta_x));
                pos_y_next = sat_pos(SUM_W'(base_y) + SUM_W'(delta_y));
                ox_next    = sat_out(pos_x_next);
                oy_next    = sat_out(pos_y_next);
                state_next = ST_SQR;
            end
            ST_SQR:
            begin
                dsq_next   = DSQ_W'($unsigned(dx_sq)) + DSQ_W'($unsigned(dy_sq));
                tsq_next   = cfg.near_threshold * cfg.near_threshold;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_x_next     = ox_reg;
                    out_y_next     = oy_reg;
                    out_last_next  = seg_reg.last;
                    out_near_next  = seg_reg.last && (dsq_reg < DSQ_W'(tsq_reg));
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        seg_reg    <= seg_next;
        cnt_reg    <= cnt_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        z_reg      <= z_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        ox_reg     <= ox_next;
        oy_reg     <= oy_next;
        dsq_reg    <= dsq_next;
        tsq_reg    <= tsq_next;
        out_x_reg  <= out_x_next;
        out_y_reg  <= out_y_next;
        out_last_reg <= out_last_next;
        out_near_reg <= out_near_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/planar_arm_forward_kinematics_unit.sv =====
// top level of the planar arm forward kinematics unit: stream ports, configuration registers
// depends on pafk_pkg, pafk_front, pafk_queue, pafk_back
//
// Each input word is one arm segment (relative angle in 1/64 degree, length); tuser marks the
// first segment of a chain and clears angle and position, tlast marks the last one. Every word
// gives one output word with the joint position of the segment end, X from the sine and Y from
// the cosine, saturated to 24 bits; on the last segment tuser reports whether that point lies
// strictly closer than near_threshold to (target_x, target_y). The back end runs a segment
// through load, 16 iterations of the shared cordic rotator, multiply, accumulate, square and
// output load. The front end classifies words and a four-entry queue lets it accept up to four
// segments ahead of the back end. The user must write configuration registers with cfg_write,
// cfg_index and cfg_data only while no segment is in flight; the block does not enforce it.
`default_nettype none

module planar_arm_forward_kinematics_unit
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // segment_angle [15:0], segment_length [31:16]
    input  wire logic        s_axis_tuser,   // chain_start
    input  wire logic        s_axis_tlast,   // chain_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [47:0]      m_axis_tdata,   // joint_x [23:0], joint_y [47:24]
    output logic             m_axis_tuser,   // near_target
    output logic             m_axis_tlast,   // is_last
    input  wire logic        cfg_write,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import pafk_pkg::*;

    cfg_t             cfg_reg, cfg_next;
    seg_t             push_data;
    seg_t             pop_data;
    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    logic [OUT_W-1:0] joint_x;
    logic [OUT_W-1:0] joint_y;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_TARGET_X:       cfg_next.target_x       = cfg_data;
                REG_TARGET_Y:       cfg_next.target_y       = cfg_data;
                REG_NEAR_THRESHOLD: cfg_next.near_threshold = cfg_data[THR_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    pafk_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_angle  (s_axis_tdata[15:0]),
        .in_length (s_axis_tdata[31:16]),
        .in_start  (s_axis_tuser),
        .in_last   (s_axis_tlast),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (push_data)
    );

    pafk_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .full      (q_full),
        .valid     (q_valid),
        .pop_data  (pop_data),
        .pop       (q_pop)
    );

    pafk_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (pop_data),
        .q_pop     (q_pop),
        .cfg       (cfg_reg),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_x     (joint_x),
        .out_y     (joint_y),
        .out_last  (m_axis_tlast),
        .out_near  (m_axis_tuser)
    );

    assign m_axis_tdata = {joint_y, joint_x};

endmodule

`default_nettype wire

// ===== dv/tb_planar_arm_forward_kinematics_unit.sv =====
// self-checking testbench for planar_arm_forward_kinematics_unit: directed segment table, long
// straight runs, then random arm chains under random stalls, every output word checked against
// an in-bench predictor; depends on pafk_pkg and the rtl of planar_arm_forward_kinematics_unit
`timescale 1ns / 1ps

module tb_planar_arm_forward_kinematics_unit;

    import pafk_pkg::*;

    localparam int     TURN_UNITS     = 23040;
    localparam int     QUADRANT_UNITS = 5760;
    localparam longint GAIN_Q30       = 64'sd652032874;
    localparam longint ROUND_HALF     = 64'sd536870912;
    localparam int     PHASE_ITEMS    = 76;
    localparam int     LONG_HOLD_AT   = 150;
    localparam int     LONG_HOLD_LEN  = 300;
    localparam int     TAIL_CYCLES    = 40;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     REPORT_CAP     = 40;

    localparam logic [1:0]         REG_UNUSED = 2'd3;
    localparam logic signed [15:0] U_TURN     = 16'sd11520;

    localparam longint ATAN_STEPS [24] = '{
        11796480, 6963869, 3679517, 1867780, 937515, 469214, 234664, 117339,
        58671, 29335, 14668, 7334, 3667, 1833, 917, 458,
        229, 115, 57, 29, 14, 7, 4, 2
    };

    typedef struct packed {
        logic signed [OUT_W-1:0] x;
        logic signed [OUT_W-1:0] y;
        logic                    last;
        logic                    near;
    } joint_t;

    typedef enum logic {PLAN_SEG, PLAN_REG} plan_kind_t;

    typedef struct packed {
        plan_kind_t  kind;
        logic [1:0]  reg_idx;
        logic [23:0] reg_val;
        logic [15:0] angle;
        logic [15:0] len;
        logic        start;
        logic        fin;
        logic        typed;
        joint_t      want;
    } plan_row_t;

    localparam joint_t NO_JOINT         = '0;
    localparam joint_t ORIGIN_MID       = '{x: '0, y: '0, last: 1'b0, near: 1'b0};
    localparam joint_t ORIGIN_LAST_FAR  = '{x: '0, y: '0, last: 1'b1, near: 1'b0};
    localparam joint_t ORIGIN_LAST_NEAR = '{x: '0, y: '0, last: 1'b1, near: 1'b1};

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_data;

    // predictor state and register copies
    int                    arm_heading = 0;
    longint                arm_x = 0;
    longint                arm_y = 0;
    logic signed [23:0]    aim_x = '0;
    logic signed [23:0]    aim_y = '0;
    logic [THR_W-1:0]      near_limit = '0;

    joint_t    joint_queue [$];
    plan_row_t warmup_plan [24];

    bit calm = 1'b0;
    int segments_sent = 0;
    int reg_writes = 0;
    int results_seen = 0;
    int chain_ends = 0;
    int near_hits = 0;
    int clipped = 0;
    int mismatches = 0;

    planar_arm_forward_kinematics_unit u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint clamp(input longint v, input int w);
        longint peak;
        peak = (longint'(1) <<< (w - 1)) - 1;
        if (v > peak)
            return peak;
        if (v < -peak - 1)
            return -peak - 1;
        return v;
    endfunction

    function automatic joint_t advance_arm(input logic signed [15:0] rel, input logic [15:0] len,
                                           input logic start, input logic fin);
        int     heading;
        longint cx, cy, cz, sx, sy, sn, cs, px, py, dx, dy, lim;
        joint_t j;
        if (start)
        begin
            arm_heading = 0;
            arm_x = 0;
            arm_y = 0;
        end
        heading = (int'(rel) + arm_heading) % TURN_UNITS;
        if (heading < 0)
            heading += TURN_UNITS;
        arm_heading = heading;
        // rotation-mode cordic on the angle within its quadrant
        cx = GAIN_Q30;
        cy = 0;
        cz = longint'(heading % QUADRANT_UNITS) * 4096;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            sx = cy >>> i;
            sy = cx >>> i;
            if (cz >= 0)
            begin
                cx -= sx;
                cy += sy;
                cz -= ATAN_STEPS[i];
            end
            else
            begin
                cx += sx;
                cy -= sy;
                cz += ATAN_STEPS[i];
            end
        end
        case (heading / QUADRANT_UNITS)
            0:
            begin
                sn = cy;
                cs = cx;
            end
            1:
            begin
                sn = cx;
                cs = -cy;
            end
            2:
            begin
                sn = -cy;
                cs = -cx;
            end
            default:
            begin
                sn = -cx;
                cs = cy;
            end
        endcase
        // x follows the sine, y the cosine
        arm_x = clamp(arm_x + ((longint'(len) * sn + ROUND_HALF) >>> 30), POS_WIDTH);
        arm_y = clamp(arm_y + ((longint'(len) * cs + ROUND_HALF) >>> 30), POS_WIDTH);
        px = clamp(arm_x, OUT_W);
        py = clamp(arm_y, OUT_W);
        j.x = px[OUT_W-1:0];
        j.y = py[OUT_W-1:0];
        j.last = fin;
        j.near = 1'b0;
        if (fin)
        begin
            dx = px - longint'(aim_x);
            dy = py - longint'(aim_y);
            lim = longint'(near_limit);
            j.near = (dx * dx + dy * dy < lim * lim);
        end
        return j;
    endfunction

    task automatic send_segment(input logic signed [15:0] rel, input logic [15:0] len,
                                input logic start, input logic fin,
                                input logic typed, input joint_t typed_j);
        joint_t j;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, rel};
        s_axis_tuser  <= start;
        s_axis_tlast  <= fin;
        do
            @(posedge clk);
        while (!s_axis_tready);
        j = advance_arm(rel, len, start, fin);
        joint_queue.insert(joint_queue.size(), typed ? typed_j : j);
        segments_sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (joint_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [23:0] val);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_TARGET_X:       aim_x = val;
            REG_TARGET_Y:       aim_y = val;
            REG_NEAR_THRESHOLD: near_limit = val[THR_W-1:0];
            default:            ;
        endcase
        cfg_write <= 1'b0;
        @(posedge clk);
        reg_writes++;
    endtask

    // straight run at full length, turning back for the last few segments
    task automatic run_straight(input logic signed [15:0] heading, input int count);
        logic signed [15:0] rel;
        for (int k = 0; k < count; k++)
        begin
            rel = (k == 0) ? heading : ((k == count - 8) ? U_TURN : 16'sd0);
            send_segment(rel, 16'hFFFF, k == 0, k == count - 1, 1'b0, NO_JOINT);
        end
    endtask

    task automatic run_chain();
        int                 count;
        logic signed [15:0] rel;
        logic [15:0]        len;
        logic               start;
        logic               fin;
        count = $urandom_range(1, 10);
        for (int k = 0; k < count; k++)
        begin
            case ($urandom_range(0, 7))
                0:       rel = 16'($urandom);
                1:       rel = 16'((int'($urandom_range(0, 8)) - 4) * QUADRANT_UNITS);
                2:       rel = 16'(int'($urandom_range(0, 64)) - 32);
                default: rel = 16'(int'($urandom_range(0, 46080)) - TURN_UNITS);
            endcase
            case ($urandom_range(0, 7))
                0:       len = '0;
                1:       len = '1;
                2:       len = 16'($urandom_range(1, 255));
                default: len = 16'($urandom);
            endcase
            start = (k == 0);
            fin = (k == count - 1);
            if ($urandom_range(0, 9) == 0)
            begin
                start = 1'($urandom);
                fin = 1'($urandom);
            end
            send_segment(rel, len, start, fin, 1'b0, NO_JOINT);
        end
    endtask

    function automatic void flag_field(input string what, input longint want, input longint got);
        mismatches++;
        if (mismatches <= REPORT_CAP)
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    endfunction

    // output side: checks every word and throttles tready
    initial
    begin
        int     stall_left;
        bit     long_hold_done;
        joint_t got;
        joint_t want;
        stall_left = 0;
        long_hold_done = 1'b0;
        m_axis_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.x = m_axis_tdata[23:0];
                got.y = m_axis_tdata[47:24];
                got.last = m_axis_tlast;
                got.near = m_axis_tuser;
                results_seen++;
                if (joint_queue.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $display("%0t: unexpected word x %0d y %0d", $time, got.x, got.y);
                end
                else
                begin
                    want = joint_queue.pop_front();
                    if (got.x != want.x)
                        flag_field("joint_x", want.x, got.x);
                    if (got.y != want.y)
                        flag_field("joint_y", want.y, got.y);
                    if (got.last != want.last)
                        flag_field("is_last", want.last, got.last);
                    if (got.near != want.near)
                        flag_field("near_target", want.near, got.near);
                    chain_ends += want.last;
                    near_hits += want.near;
                    if (want.x == 24'sh7FFFFF || want.x == 24'sh800000 ||
                        want.y == 24'sh7FFFFF || want.y == 24'sh800000)
                        clipped++;
                end
            end
            if (stall_left == 0 && !long_hold_done && results_seen >= LONG_HOLD_AT)
            begin
                stall_left = LONG_HOLD_LEN;
                long_hold_done = 1'b1;
            end
            else if (stall_left == 0 && !calm && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 9);
            if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("planar_arm_forward_kinematics_unit: mismatch");
        $finish;
    end

    initial
    begin
        logic [23:0] tx;
        logic [23:0] ty;
        logic [23:0] thr;
        int          mark;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        cfg_write     <= 1'b0;
        cfg_index     <= REG_TARGET_X;
        cfg_data      <= '0;
        warmup_plan = '{
            '{PLAN_SEG, '0, '0, 16'sd0, 16'd0, 1'b1, 1'b1, 1'b1, ORIGIN_LAST_FAR},
            '{PLAN_SEG, '0, '0, 16'sd0, 16'hFFFF, 1'b1, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, 16'sd23040, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, -16'sd23040, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, 16'sd5760, 16'd1, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, 16'sd11520, 16'd40000, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, -16'sd5760, 16'd12345, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, 16'h7FFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, 16'h8000, 16'hFFFF, 1'b0, 1'b1, 1'b0, NO_JOINT},
            '{PLAN_REG, REG_TARGET_X, 24'h000000, '0, '0, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_REG, REG_TARGET_Y, 24'h000000, '0, '0, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_REG, REG_NEAR_THRESHOLD, 24'h000001, '0, '0, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, 16'sd0, 16'd0, 1'b1, 1'b0, 1'b1, ORIGIN_MID},
            '{PLAN_SEG, '0, '0, 16'sd0, 16'd0, 1'b1, 1'b1, 1'b1, ORIGIN_LAST_NEAR},
            '{PLAN_SEG, '0, '0, 16'sd7000, 16'd0, 1'b1, 1'b1, 1'b1, ORIGIN_LAST_NEAR},
            '{PLAN_REG, REG_TARGET_X, 24'h7FFFFF, '0, '0, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_REG, REG_TARGET_Y, 24'h800000, '0, '0, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_REG, REG_NEAR_THRESHOLD, 24'h7FFFFF, '0, '0, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, 16'sd0, 16'd0, 1'b1, 1'b1, 1'b1, ORIGIN_LAST_FAR},
            '{PLAN_SEG, '0, '0, 16'sd17280, 16'hFFFF, 1'b1, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, 16'sd1, 16'hFFFF, 1'b0, 1'b1, 1'b0, NO_JOINT},
            '{PLAN_REG, REG_UNUSED, 24'hFFFFFF, '0, '0, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, 16'sd2880, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_JOINT},
            '{PLAN_SEG, '0, '0, -16'sd1, 16'd54321, 1'b0, 1'b1, 1'b0, NO_JOINT}
        };
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (warmup_plan[r])
        begin
            if (warmup_plan[r].kind == PLAN_REG)
                write_reg(warmup_plan[r].reg_idx, warmup_plan[r].reg_val);
            else
                send_segment(warmup_plan[r].angle, warmup_plan[r].len, warmup_plan[r].start,
                             warmup_plan[r].fin, warmup_plan[r].typed, warmup_plan[r].want);
        end

        // long full-length runs at 45 and 225 degrees drive both coordinates into saturation
        write_reg(REG_TARGET_X, 24'h7FFFFF);
        write_reg(REG_TARGET_Y, 24'h7FFFFF);
        write_reg(REG_NEAR_THRESHOLD, 24'd600000);
        run_straight(16'sd2880, 200);
        run_straight(16'sd14400, 200);

        for (int p = 1; p < 8; p++)
        begin
            case (p)
                1:
                begin
                    tx = 24'h800000;
                    ty = 24'h800000;
                    thr = 24'h7FFFFF;
                end
                2:
                begin
                    tx = 24'h7FFFFF;
                    ty = 24'h800000;
                    thr = '0;
                end
                6:
                begin
                    tx = 24'($urandom);
                    ty = 24'($urandom);
                    thr = 24'($urandom_range(0, 24'h7FFFFF));
                end
                default:
                begin
                    tx = 24'(int'($urandom_range(0, 1200000)) - 600000);
                    ty = 24'(int'($urandom_range(0, 1200000)) - 600000);
                    thr = 24'($urandom_range(0, 900000));
                end
            endcase
            write_reg(REG_TARGET_X, tx);
            write_reg(REG_TARGET_Y, ty);
            write_reg(REG_NEAR_THRESHOLD, thr);
            if (p == 4 || p == 6)
                write_reg(REG_UNUSED, 24'($urandom));
            calm = (p == 3 || p == 7);
            mark = segments_sent;
            while (segments_sent - mark < PHASE_ITEMS)
                run_chain();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d segments, %0d chain ends, %0d near the target, %0d clipped joints",
                 segments_sent, chain_ends, near_hits, clipped);
        $display("%0d register writes, one long output hold, %0d mismatches",
                 reg_writes, mismatches);
        if (mismatches == 0)
            $display("planar_arm_forward_kinematics_unit: match");
        else
            $display("planar_arm_forward_kinematics_unit: mismatch");
        $finish;
    end

endmodule
